@@ src/ple_pkg.sv @@
`default_nettype none

package ple_pkg;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ST_W   = 2;

  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rot;
    logic [CNT_W-1:0] idx;
    logic             load;
    logic [ST_W-1:0]  status;
    logic             elem_valid;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/ple_ctrl.sv @@
`default_nettype none

module ple_ctrl import ple_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] op_i,
  input  wire logic [CNT_W-1:0] position_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire dp_sts_t         sts_i,
  output dp_cmd_t              cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  logic             state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, accept, full, empty, dump_last;
  logic [CNT_W:0]   pos_w, cnt_w;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    in_ready_o  = (state_q == ST_IDLE) && out_free;
    accept      = in_valid_i && in_ready_o;
    full        = (sts_i.count == CapCnt);
    empty       = (sts_i.count == '0);
    pos_w       = {1'b0, position_i};
    cnt_w       = {1'b0, sts_i.count};
    dump_last   = (k_q == sts_i.count - CNT_W'(1));
    state_d     = state_q;
    k_d         = k_q;
    cmd_o       = '0;
    if (accept) begin
      cmd_o.load = 1'b1;
      cmd_o.last = 1'b1;
      cmd_o.status = ST_OK;
      unique case (op_i)
        OP_INS_POS: begin
          if (position_i == '0 || pos_w > cnt_w + (CNT_W+1)'(1)) begin
            cmd_o.status = ST_BADPOS;
          end else if (full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.ins = 1'b1;
            cmd_o.idx = position_i - CNT_W'(1);
          end
        end
        OP_DEL_POS: begin
          if (position_i == '0 || pos_w > cnt_w) begin
            cmd_o.status = ST_BADPOS;
          end else begin
            cmd_o.del = 1'b1;
            cmd_o.idx = position_i - CNT_W'(1);
          end
        end
        OP_INS_FIRST: begin
          if (full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.ins = 1'b1;
          end
        end
        OP_INS_LAST: begin
          if (full) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.ins = 1'b1;
            cmd_o.idx = sts_i.count;
          end
        end
        OP_DEL_FIRST: begin
          if (empty) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.del = 1'b1;
          end
        end
        OP_DEL_LAST: begin
          if (empty) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.del = 1'b1;
            cmd_o.idx = sts_i.count - CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (!empty) begin
            cmd_o.load = 1'b0;
            state_d    = ST_DUMP;
            k_d        = '0;
          end
        end
        default: ;
      endcase
    end else if (state_q == ST_DUMP && out_free) begin
      // emit head, rotate list left by one within count
      cmd_o.load       = 1'b1;
      cmd_o.rot        = 1'b1;
      cmd_o.status     = ST_OK;
      cmd_o.elem_valid = 1'b1;
      cmd_o.last       = dump_last;
      k_d              = k_q + CNT_W'(1);
      if (dump_last) begin
        state_d = ST_IDLE;
      end
    end
    out_valid_d = cmd_o.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |-> (sts_i.count != CapCnt))
    else $error("insert into full list");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (sts_i.count != '0 && k_q < sts_i.count))
    else $error("dump index out of range");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rot && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("dump did not return to idle");
`endif

endmodule

`default_nettype wire

@@ src/ple_dpath.sv @@
`default_nettype none

module ple_dpath import ple_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  input  wire logic [VAL_W-1:0] value_i,
  output dp_sts_t               sts_o,
  output logic [ST_W-1:0]       res_status_o,
  output logic [VAL_W-1:0]      res_element_o,
  output logic                  res_elem_valid_o,
  output logic [CNT_W-1:0]      res_count_o,
  output logic                  res_last_o
);

  logic [VAL_W-1:0] cell_q [CAPACITY];
  logic [VAL_W-1:0] nb_lo  [CAPACITY];
  logic [VAL_W-1:0] nb_hi  [CAPACITY];
  logic [CNT_W-1:0] count_q, count_d, count_m1;

  assign count_m1 = count_q - CNT_W'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] Idx = CNT_W'(i);
    logic [VAL_W-1:0] cell_d;
    logic             cell_we;

    if (i == 0) begin : g_lo0
      assign nb_lo[i] = '0;
    end else begin : g_lo
      assign nb_lo[i] = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hiN
      assign nb_hi[i] = '0;
    end else begin : g_hi
      assign nb_hi[i] = cell_q[i+1];
    end

    always_comb begin
      cell_we = 1'b0;
      cell_d  = cell_q[i];
      if (cmd_i.ins) begin
        if (Idx == cmd_i.idx) begin
          cell_we = 1'b1;
          cell_d  = value_i;
        end else if (Idx > cmd_i.idx && Idx <= count_q) begin
          cell_we = 1'b1;
          cell_d  = nb_lo[i];
        end
      end else if (cmd_i.del || cmd_i.rot) begin
        if (Idx >= cmd_i.idx && Idx < count_m1) begin
          cell_we = 1'b1;
          cell_d  = nb_hi[i];
        end else if (cmd_i.rot && Idx == count_m1) begin
          cell_we = 1'b1;
          cell_d  = cell_q[0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cell_we) begin
        cell_q[i] <= cell_d;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.del) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_status_o     <= cmd_i.status;
      res_element_o    <= cmd_i.rot ? cell_q[0] : '0;
      res_elem_valid_o <= cmd_i.elem_valid;
      res_count_o      <= count_d;
      res_last_o       <= cmd_i.last;
    end
  end

  assign sts_o.count = count_q;

endmodule

`default_nettype wire

@@ src/positional_list_engine.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tdata: op[2:0] value[34:3] position[41:35]
// m_axis    out  tdata: status[1:0] element[33:2] count[40:34]; tuser: valid; tlast
//
// Insert, delete and control requests: one result, available the cycle after acceptance;
//   a new request is taken once that result is taken or in the same cycle.
// Dump: max(count,1) results, one per unstalled cycle, by rotating cells past head.
// Reset clears the element count; cell contents need no clearing.
// Output register holds a result while m_axis_tready_i is low.
`default_nettype none

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // op[2:0], value[34:3], position[41:35]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // status[1:0], element[33:2], count[40:34]
  output logic             m_axis_tuser_o,  // element_valid
  output logic             m_axis_tlast_o
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [ST_W-1:0]  res_status;
  logic [VAL_W-1:0] res_element;
  logic [CNT_W-1:0] res_count;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tdata_i[2:0]),
    .position_i  (s_axis_tdata_i[41:35]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ple_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .value_i          (s_axis_tdata_i[34:3]),
    .sts_o            (sts),
    .res_status_o     (res_status),
    .res_element_o    (res_element),
    .res_elem_valid_o (m_axis_tuser_o),
    .res_count_o      (res_count),
    .res_last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, res_count, res_element, res_status};

endmodule

`default_nettype wire
